/* rtl/preorder_tree_table_unit_defines.svh */
// Assertion macros used by the preorder tree table engine.
`ifndef PREORDER_TREE_TABLE_UNIT_DEFINES_SVH
`define PREORDER_TREE_TABLE_UNIT_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define PTT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its cause.
`define PTT_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that holds in the cycle after its cause.
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ptt_pkg.sv */
// Package with the types, sizes and codes of the preorder tree table.
`timescale 1ns / 1ps

package ptt_pkg;

   localparam int MaxNodes = 64;
   localparam int IdBits   = 16;
   localparam int AddrBits = $clog2(MaxNodes);
   localparam int CntBits  = AddrBits + 1;
   localparam int CmdBits  = 2;
   localparam int StatBits = 2;

   localparam logic [CmdBits-1:0] CMD_ROOT   = 2'd0;
   localparam logic [CmdBits-1:0] CMD_INSERT = 2'd1;
   localparam logic [CmdBits-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CmdBits-1:0] CMD_FIND   = 2'd3;

   localparam logic [StatBits-1:0] STAT_OK       = 2'd0;
   localparam logic [StatBits-1:0] STAT_NOTFOUND = 2'd1;
   localparam logic [StatBits-1:0] STAT_FULL     = 2'd2;

   typedef struct packed {
      logic [IdBits-1:0]   id;
      logic [IdBits-1:0]   parent;
      logic                is_root;
      logic [AddrBits-1:0] slot;
      logic [CntBits-1:0]  sub;
   } ptt_entry_type;

   typedef struct packed {
      logic [CmdBits-1:0] command;
      logic [IdBits-1:0]  node_id;
   } ptt_req_type;

   typedef struct packed {
      logic [StatBits-1:0] status;
      logic [IdBits-1:0]   new_id;
      logic [AddrBits-1:0] position;
      logic [AddrBits-1:0] slot;
      logic [CntBits-1:0]  removed_count;
   } ptt_rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } ptt_core_state_type;

endpackage

/* rtl/ptt_intf.sv */
// Valid/ready channel interfaces for the command and result beats.
`timescale 1ns / 1ps

interface ptt_req_if;
   import ptt_pkg::*;

   logic               valid;
   logic               ready;
   logic [CmdBits-1:0] command;
   logic [IdBits-1:0]  node_id;

   modport source (output valid, output command, output node_id, input ready);
   modport sink (input valid, input command, input node_id, output ready);
endinterface

interface ptt_rsp_if;
   import ptt_pkg::*;

   logic                valid;
   logic                ready;
   logic [StatBits-1:0] status;
   logic [IdBits-1:0]   new_id;
   logic [AddrBits-1:0] position;
   logic [AddrBits-1:0] slot;
   logic [CntBits-1:0]  removed_count;

   modport source (output valid, output status, output new_id, output position,
                   output slot, output removed_count, input ready);
   modport sink (input valid, input status, input new_id, input position,
                 input slot, input removed_count, output ready);
endinterface

/* rtl/ptt_engine.sv */
// Table memory and pass sequencer that carry out one tree command at a time.
`timescale 1ns / 1ps
`include "preorder_tree_table_unit_defines.svh"

module ptt_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  ptt_pkg::ptt_req_type        cmd_req,
   input  logic                        ack,
   output ptt_pkg::ptt_core_state_type core_state,
   output ptt_pkg::ptt_rsp_type        result
);
   import ptt_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_SHIFT_UP = 3'd2;
   localparam logic [2:0] S_NEW      = 3'd3;
   localparam logic [2:0] S_ANC      = 3'd4;
   localparam logic [2:0] S_SHIFT_DN = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CmdBits-1:0]  cmd_ff, cmd_in;
   logic [IdBits-1:0]   key_ff, key_in;
   logic [CntBits-1:0]  idx_ff, idx_in;
   logic [CntBits-1:0]  lim_ff, lim_in;
   logic [AddrBits-1:0] tgt_ff, tgt_in;
   logic [CntBits-1:0]  rm_ff, rm_in;
   logic [CntBits-1:0]  count_ff, count_in;
   logic [IdBits-1:0]   id_ctr_ff, id_ctr_in;
   ptt_rsp_type         res_ff, res_in;

   ptt_entry_type       entry_mem_ff [MaxNodes];
   ptt_entry_type       rd_data_ff;
   logic                rd_vld_ff;
   logic [2:0]          rd_tag_ff;
   logic [AddrBits-1:0] rd_idx_ff;

   logic                rd_en;
   logic [AddrBits-1:0] rd_addr;
   logic                wr_en;
   logic [AddrBits-1:0] wr_addr;
   ptt_entry_type       wr_data;

   logic                data_ok;
   logic                hit;
   logic                full;
   logic [CntBits:0]    span;
   logic                covers;
   logic [CntBits-1:0]  sub_adj;
   logic [CntBits:0]    rm_want;
   logic [CntBits-1:0]  rm_avail;
   logic [AddrBits-1:0] new_pos;

   // Read data is only used by the state that issued the read.
   assign data_ok = rd_vld_ff && (rd_tag_ff == state_ff);
   assign hit     = data_ok && (state_ff == S_SCAN) && (rd_data_ff.id == key_ff);
   assign full    = (count_ff == CntBits'(MaxNodes));

   // Shared compare and adjust unit: an entry is an ancestor of the target
   // when its subtree range reaches the target position.
   assign span     = (CntBits+1)'(rd_idx_ff) + (CntBits+1)'(rd_data_ff.sub);
   assign covers   = (span >= (CntBits+1)'(tgt_ff));
   assign sub_adj  = (cmd_ff == CMD_INSERT) ? rd_data_ff.sub + CntBits'(1) :
                     (rd_data_ff.sub >= rm_ff) ? rd_data_ff.sub - rm_ff : '0;
   assign rm_want  = (CntBits+1)'(rd_data_ff.sub) + (CntBits+1)'(1);
   assign rm_avail = count_ff - CntBits'(rd_idx_ff);
   assign new_pos  = (cmd_ff == CMD_ROOT) ? count_ff[AddrBits-1:0] : tgt_ff + AddrBits'(1);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      lim_in    = lim_ff;
      tgt_in    = tgt_ff;
      rm_in     = rm_ff;
      count_in  = count_ff;
      id_ctr_in = id_ctr_ff;
      res_in    = res_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[AddrBits-1:0];
      wr_en     = 1'b0;
      wr_addr   = rd_idx_ff;
      wr_data   = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = cmd_req.command;
               key_in = cmd_req.node_id;
               res_in = '0;
               if (cmd_req.command == CMD_ROOT) begin
                  if (full) begin
                     res_in.status = STAT_FULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_NEW;
                  end
               end else if (count_ff == '0) begin
                  res_in.status = STAT_NOTFOUND;
                  state_in      = S_DONE;
               end else begin
                  idx_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            rd_en = (idx_ff < count_ff) && !hit;
            if (rd_en) begin
               idx_in = idx_ff + CntBits'(1);
            end
            if (hit) begin
               tgt_in = rd_idx_ff;
               case (cmd_ff)
                  CMD_FIND: begin
                     res_in.position = rd_idx_ff;
                     res_in.slot     = rd_data_ff.slot;
                     state_in        = S_DONE;
                  end
                  CMD_INSERT: begin
                     if (full) begin
                        res_in.status = STAT_FULL;
                        state_in      = S_DONE;
                     end else begin
                        idx_in   = count_ff - CntBits'(1);
                        lim_in   = CntBits'(rd_idx_ff) + CntBits'(1);
                        state_in = S_SHIFT_UP;
                     end
                  end
                  CMD_REMOVE: begin
                     if (rm_want > (CntBits+1)'(rm_avail)) begin
                        rm_in = rm_avail;
                     end else begin
                        rm_in = rm_want[CntBits-1:0];
                     end
                     res_in.position = rd_idx_ff;
                     idx_in          = '0;
                     lim_in          = CntBits'(rd_idx_ff);
                     state_in        = S_ANC;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end else if (data_ok &&
                         (rd_idx_ff == count_ff[AddrBits-1:0] - AddrBits'(1))) begin
               res_in.status = STAT_NOTFOUND;
               state_in      = S_DONE;
            end
         end

         S_SHIFT_UP: begin
            // Walk down from the last entry so nothing is overwritten before it moves.
            rd_en = (idx_ff >= lim_ff);
            if (rd_en) begin
               idx_in = idx_ff - CntBits'(1);
            end
            wr_en   = data_ok;
            wr_addr = rd_idx_ff + AddrBits'(1);
            if (!rd_en && !data_ok) begin
               state_in = S_NEW;
            end
         end

         S_NEW: begin
            wr_en           = 1'b1;
            wr_addr         = new_pos;
            wr_data.id      = id_ctr_ff;
            wr_data.parent  = (cmd_ff == CMD_ROOT) ? '1 : key_ff;
            wr_data.is_root = (cmd_ff == CMD_ROOT);
            wr_data.slot    = count_ff[AddrBits-1:0];
            wr_data.sub     = '0;
            id_ctr_in       = id_ctr_ff + IdBits'(1);
            count_in        = count_ff + CntBits'(1);
            res_in.status   = STAT_OK;
            res_in.new_id   = id_ctr_ff;
            res_in.position = new_pos;
            res_in.slot     = count_ff[AddrBits-1:0];
            if (cmd_ff == CMD_ROOT) begin
               state_in = S_DONE;
            end else begin
               idx_in   = '0;
               lim_in   = CntBits'(tgt_ff) + CntBits'(1);
               state_in = S_ANC;
            end
         end

         S_ANC: begin
            rd_en = (idx_ff < lim_ff);
            if (rd_en) begin
               idx_in = idx_ff + CntBits'(1);
            end
            wr_en       = data_ok && covers;
            wr_addr     = rd_idx_ff;
            wr_data.sub = sub_adj;
            if (!rd_en && !data_ok) begin
               if (cmd_ff == CMD_REMOVE) begin
                  idx_in   = CntBits'(tgt_ff) + rm_ff;
                  state_in = S_SHIFT_DN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_SHIFT_DN: begin
            rd_en = (idx_ff < count_ff);
            if (rd_en) begin
               idx_in = idx_ff + CntBits'(1);
            end
            wr_en   = data_ok;
            wr_addr = rd_idx_ff - rm_ff[AddrBits-1:0];
            if (!rd_en && !data_ok) begin
               count_in             = count_ff - rm_ff;
               res_in.removed_count = rm_ff;
               state_in             = S_DONE;
            end
         end

         S_DONE: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         id_ctr_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         id_ctr_ff <= id_ctr_in;
         rd_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      lim_ff    <= lim_in;
      tgt_ff    <= tgt_in;
      rm_ff     <= rm_in;
      res_ff    <= res_in;
      rd_tag_ff <= state_ff;
      rd_idx_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign core_state.idle = (state_ff == S_IDLE);
   assign core_state.done = (state_ff == S_DONE);
   assign result          = res_ff;

   `PTT_ASSERT_ALWAYS(a_count_bound, count_ff <= CntBits'(MaxNodes),
      "entry count exceeds the table size")
   `PTT_ASSERT_IMPLIES(a_write_in_range, wr_en, CntBits'(wr_addr) <= count_ff,
      "table write beyond the end of the valid entries")
   `PTT_ASSERT_IMPLIES(a_id_step, !$past(reset) && (id_ctr_ff != $past(id_ctr_ff)),
      $past(state_ff) == S_NEW, "id counter moved without a new entry")
   `PTT_ASSERT_IMPLIES(a_removed_only_remove,
      core_state.done && (res_ff.removed_count != '0),
      (cmd_ff == CMD_REMOVE) && (res_ff.status == STAT_OK),
      "removed count reported for a command that removed nothing")
   `PTT_ASSERT_NEXT(a_done_holds, core_state.done && !ack, core_state.done,
      "result dropped before it was taken")

endmodule

/* rtl/preorder_tree_table_unit.sv */
// Top level of the preorder tree table: channel handshakes and result register.
//
// Usage: the req channel carries one command beat (command, node_id); the rsp
// channel returns exactly one result beat (status, new_id, position, slot,
// removed_count) per command, in command order. Both use valid/ready.
// The block serves one command at a time; req.ready is high only while the
// engine is idle. Every pass over the table reads one entry per cycle through
// the single read port of the entry memory. With N entries and the match at
// position f, the passes run in this order:
//   new root: write the new entry; find: scan up to f;
//   insert: scan to f, shift later entries up, write the new entry, update ancestors;
//   remove: scan to f, update ancestors, shift the entries after the subtree down.
// A finished result moves into the output register, so a new command beat is
// taken while an earlier result waits on a stalled rsp.ready; the engine then
// holds its next result until the register frees up.
// Reset empties the table and restarts ids at zero; it takes no clearing pass.
`timescale 1ns / 1ps

module preorder_tree_table_unit (
   input  logic      clock,
   input  logic      reset,
   ptt_req_if.sink   req,
   ptt_rsp_if.source rsp
);
   import ptt_pkg::*;

   ptt_core_state_type core_state;
   ptt_rsp_type        core_result;
   ptt_req_type        cmd_req;
   logic               start;
   logic               ack;
   logic               rsp_valid_ff, rsp_valid_in;
   ptt_rsp_type        rsp_data_ff;

   assign req.ready       = core_state.idle;
   assign start           = req.valid && core_state.idle;
   assign cmd_req.command = req.command;
   assign cmd_req.node_id = req.node_id;

   // The engine hands over its result when the output register is empty or draining.
   assign ack = core_state.done && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ack) begin
         rsp_data_ff <= core_result;
      end
   end

   ptt_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cmd_req    (cmd_req),
      .ack        (ack),
      .core_state (core_state),
      .result     (core_result)
   );

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_data_ff.status;
   assign rsp.new_id        = rsp_data_ff.new_id;
   assign rsp.position      = rsp_data_ff.position;
   assign rsp.slot          = rsp_data_ff.slot;
   assign rsp.removed_count = rsp_data_ff.removed_count;

endmodule
